/* rtl/ctok_pkg.sv */
// Shared types, token codes and keyword lookup for the C-like tokenizer.
`default_nettype none

package ctok_pkg;

    // Field widths of the token item
    localparam int POS_BITS = 24;
    localparam int LEN_BITS = 16;
    localparam int KIND_BITS = 6;

    // Default depth of the lexeme prefix store
    localparam int PREFIX_CHARS_DEF = 8;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_END      = 6'd0;
    localparam logic [KIND_BITS-1:0] K_ERR      = 6'd1;
    localparam logic [KIND_BITS-1:0] K_STR      = 6'd2;
    localparam logic [KIND_BITS-1:0] K_NUM      = 6'd3;
    localparam logic [KIND_BITS-1:0] K_ID       = 6'd4;
    localparam logic [KIND_BITS-1:0] K_KW0      = 6'd5;
    localparam logic [KIND_BITS-1:0] K_INC      = 6'd22;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd23;
    localparam logic [KIND_BITS-1:0] K_DEC      = 6'd24;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd25;
    localparam logic [KIND_BITS-1:0] K_DIV      = 6'd26;
    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd27;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd28;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd29;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd30;
    localparam logic [KIND_BITS-1:0] K_LBRACKET = 6'd31;
    localparam logic [KIND_BITS-1:0] K_RBRACKET = 6'd32;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd33;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd34;
    localparam logic [KIND_BITS-1:0] K_DOT      = 6'd35;
    localparam logic [KIND_BITS-1:0] K_MUL      = 6'd36;
    localparam logic [KIND_BITS-1:0] K_EQ       = 6'd37;
    localparam logic [KIND_BITS-1:0] K_ARROW    = 6'd38;
    localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd39;
    localparam logic [KIND_BITS-1:0] K_NE       = 6'd40;
    localparam logic [KIND_BITS-1:0] K_NOT      = 6'd41;
    localparam logic [KIND_BITS-1:0] K_LE       = 6'd42;
    localparam logic [KIND_BITS-1:0] K_LT       = 6'd43;
    localparam logic [KIND_BITS-1:0] K_GE       = 6'd44;
    localparam logic [KIND_BITS-1:0] K_GT       = 6'd45;
    localparam logic [KIND_BITS-1:0] K_AND      = 6'd46;
    localparam logic [KIND_BITS-1:0] K_AMP      = 6'd47;
    localparam logic [KIND_BITS-1:0] K_OR       = 6'd48;

    // Keywords, right-aligned with the first character most significant
    localparam int KW_COUNT = 17;
    localparam int KW_CHARS = 7;
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        56'("struct"), 56'("int"), 56'("string"), 56'("bool"), 56'("if"),
        56'("else"), 56'("while"), 56'("do"), 56'("for"), 56'("switch"),
        56'("case"), 56'("default"), 56'("break"), 56'("true"), 56'("false"),
        56'("printf"), 56'("return")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd3, 3'd6, 3'd4, 3'd2, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6,
        3'd4, 3'd7, 3'd5, 3'd4, 3'd5, 3'd6, 3'd6
    };

    // Input item
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       end_of_input;
    } ctok_in_t;

    // Result item
    typedef struct packed {
        logic [KIND_BITS-1:0] token_kind;
        logic [POS_BITS-1:0]  token_start;
        logic [LEN_BITS-1:0]  token_length;
        logic                 unclosed_comment;
        logic                 last_of_run;
    } ctok_out_t;

    // Up to three tokens caused by one input item
    typedef struct packed {
        logic [1:0]          n;
        ctok_out_t [2:0]     tok;
    } ctok_burst_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // Identifier kind: keyword code on a match, plain identifier otherwise
    function automatic logic [KIND_BITS-1:0] ctok_kw_kind(
        input logic [KW_CHARS-1:0][7:0] p,
        input logic [LEN_BITS-1:0]      n
    );
        logic [8*KW_CHARS-1:0] cand;
        logic [KIND_BITS-1:0]  k;
        cand = '0;
        k    = K_ID;
        for (int i = 0; i < KW_CHARS; i++)
        begin
            if (LEN_BITS'(i) < n)
                cand = {cand[8*KW_CHARS-9:0], p[i]};
        end
        for (int j = 0; j < KW_COUNT; j++)
        begin
            if ((n == LEN_BITS'(KW_LEN[j])) && (cand == KW_TEXT[j]))
                k = KIND_BITS'(K_KW0 + KIND_BITS'(j));
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* rtl/ctok_scan.sv */
// Scanner state and per-character token decisions of the C-like tokenizer.
`default_nettype none

module ctok_scan #(
    parameter int PREFIX_CHARS = ctok_pkg::PREFIX_CHARS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire ctok_pkg::ctok_in_t item,
    output ctok_pkg::ctok_burst_t   burst
);
    import ctok_pkg::*;

    localparam int IDX_BITS = (PREFIX_CHARS > 1) ? $clog2(PREFIX_CHARS) : 1;

    // Scan modes
    localparam logic [4:0] M_IDLE       = 5'd0;
    localparam logic [4:0] M_SLASH      = 5'd1;
    localparam logic [4:0] M_LINE       = 5'd2;
    localparam logic [4:0] M_BLOCK      = 5'd3;
    localparam logic [4:0] M_BLOCK_STAR = 5'd4;
    localparam logic [4:0] M_STR        = 5'd5;
    localparam logic [4:0] M_STR_ESC    = 5'd6;
    localparam logic [4:0] M_NUM        = 5'd7;
    localparam logic [4:0] M_IDENT      = 5'd8;
    localparam logic [4:0] M_PLUS       = 5'd9;
    localparam logic [4:0] M_MINUS      = 5'd10;
    localparam logic [4:0] M_EQ         = 5'd11;
    localparam logic [4:0] M_BANG       = 5'd12;
    localparam logic [4:0] M_LT         = 5'd13;
    localparam logic [4:0] M_GT         = 5'd14;
    localparam logic [4:0] M_AMP        = 5'd15;
    localparam logic [4:0] M_BAR        = 5'd16;

    logic [4:0]          mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] cnt_reg, cnt_next;
    logic [7:0]          pfx_reg [PREFIX_CHARS];

    // Pending token of a mode whose token waits on the next character
    function automatic logic [KIND_BITS:0] pend(
        input logic [4:0]           m,
        input logic [KIND_BITS-1:0] kwk
    );
        logic [KIND_BITS:0] r;
        r = {1'b0, K_ERR};
        case (m)
            M_SLASH: r = {1'b1, K_DIV};
            M_NUM:   r = {1'b1, K_NUM};
            M_IDENT: r = {1'b1, kwk};
            M_PLUS:  r = {1'b1, K_PLUS};
            M_MINUS: r = {1'b1, K_MINUS};
            M_EQ:    r = {1'b1, K_ASSIGN};
            M_BANG:  r = {1'b1, K_NOT};
            M_LT:    r = {1'b1, K_LT};
            M_GT:    r = {1'b1, K_GT};
            M_AMP:   r = {1'b1, K_AMP};
            M_BAR:   r = {1'b1, K_ERR};
            default: r = {1'b0, K_ERR};
        endcase
        return r;
    endfunction

    logic [7:0]             c;
    logic [4:0]             mode1;
    logic [POS_BITS-1:0]    start1, pos1;
    logic [LEN_BITS-1:0]    cnt_base, cnt1;
    logic                   do_start, do_flush, do_count, str_close;
    logic                   a_v, b_v, f_v, unc;
    logic [KIND_BITS-1:0]   a_kind, b_kind, f_kind;
    logic [LEN_BITS-1:0]    a_len, f_len;
    logic [POS_BITS-1:0]    f_start;
    logic                   pfx_we;
    logic [IDX_BITS-1:0]    pfx_idx;
    logic [KW_CHARS-1:0][7:0] cur7, nxt7;
    logic [KIND_BITS-1:0]   kw_cur, kw_fin;
    logic [KIND_BITS:0]     pend_cur, pend_fin;
    logic [1:0]             k;

    assign c = item.ch;

    // Keyword lookup on stored prefix and on prefix after this character
    always_comb
    begin
        for (int i = 0; i < KW_CHARS; i++)
        begin
            cur7[i] = pfx_reg[i];
            nxt7[i] = (pfx_we && (pfx_idx == IDX_BITS'(i))) ? c : pfx_reg[i];
        end
    end

    assign kw_cur   = ctok_kw_kind(cur7, cnt_reg);
    assign pend_cur = pend(mode_reg, kw_cur);

    // Character step
    always_comb
    begin
        mode1     = mode_reg;
        start1    = start_reg;
        cnt_base  = cnt_reg;
        do_start  = 1'b0;
        do_flush  = 1'b0;
        do_count  = 1'b0;
        str_close = 1'b0;
        a_v       = 1'b0;
        a_kind    = K_ERR;
        a_len     = LEN_BITS'(2);
        b_v       = 1'b0;
        b_kind    = K_ERR;
        if (item.has_char)
        begin
            unique case (mode_reg)
                M_IDLE: do_start = 1'b1;
                M_LINE: if (c == "\n") mode1 = M_IDLE;
                M_BLOCK: if (c == "*") mode1 = M_BLOCK_STAR;
                M_BLOCK_STAR:
                begin
                    if (c == "/")
                        mode1 = M_IDLE;
                    else if (c != "*")
                        mode1 = M_BLOCK;
                end
                M_STR:
                begin
                    do_count = 1'b1;
                    if (c == "\"")
                    begin
                        str_close = 1'b1;
                        mode1     = M_IDLE;
                    end
                    else if (c == "\\")
                        mode1 = M_STR_ESC;
                end
                M_STR_ESC:
                begin
                    do_count = 1'b1;
                    mode1    = M_STR;
                end
                M_SLASH:
                begin
                    if (c == "/")
                        mode1 = M_LINE;
                    else if (c == "*")
                        mode1 = M_BLOCK;
                    else
                        do_flush = 1'b1;
                end
                M_NUM:
                begin
                    if (is_digit(c))
                        do_count = 1'b1;
                    else
                        do_flush = 1'b1;
                end
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c) || (c == "_"))
                        do_count = 1'b1;
                    else
                        do_flush = 1'b1;
                end
                M_PLUS:
                begin
                    if (c == "+") begin a_v = 1'b1; a_kind = K_INC; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_MINUS:
                begin
                    if (c == "-") begin a_v = 1'b1; a_kind = K_DEC; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_EQ:
                begin
                    if (c == "=") begin a_v = 1'b1; a_kind = K_EQ; mode1 = M_IDLE; end
                    else if (c == ">") begin a_v = 1'b1; a_kind = K_ARROW; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_BANG:
                begin
                    if (c == "=") begin a_v = 1'b1; a_kind = K_NE; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_LT:
                begin
                    if (c == "=") begin a_v = 1'b1; a_kind = K_LE; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_GT:
                begin
                    if (c == "=") begin a_v = 1'b1; a_kind = K_GE; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_AMP:
                begin
                    if (c == "&") begin a_v = 1'b1; a_kind = K_AND; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                M_BAR:
                begin
                    if (c == "|") begin a_v = 1'b1; a_kind = K_OR; mode1 = M_IDLE; end
                    else do_flush = 1'b1;
                end
                default: do_start = 1'b1;
            endcase
        end

        // Pending token ends before this character
        if (do_flush)
        begin
            a_v      = 1'b1;
            a_kind   = pend_cur[KIND_BITS-1:0];
            a_len    = ((mode_reg == M_NUM) || (mode_reg == M_IDENT)) ?
                       cnt_reg : LEN_BITS'(1);
            do_start = 1'b1;
        end

        // Character opens a new token
        if (do_start)
        begin
            start1   = pos_reg;
            cnt_base = '0;
            mode1    = M_IDLE;
            if ((c == " ") || (c == "\t") || (c == "\r") || (c == "\n"))
                mode1 = M_IDLE;
            else if (c == "\"")
            begin
                do_count = 1'b1;
                mode1    = M_STR;
            end
            else if (is_digit(c))
            begin
                do_count = 1'b1;
                mode1    = M_NUM;
            end
            else if (is_alpha(c) || (c == "_"))
            begin
                do_count = 1'b1;
                mode1    = M_IDENT;
            end
            else
            begin
                case (c)
                    "/": mode1 = M_SLASH;
                    "+": mode1 = M_PLUS;
                    "-": mode1 = M_MINUS;
                    "=": mode1 = M_EQ;
                    "!": mode1 = M_BANG;
                    "<": mode1 = M_LT;
                    ">": mode1 = M_GT;
                    "&": mode1 = M_AMP;
                    "|": mode1 = M_BAR;
                    "(": begin b_v = 1'b1; b_kind = K_LPAREN;   end
                    ")": begin b_v = 1'b1; b_kind = K_RPAREN;   end
                    "{": begin b_v = 1'b1; b_kind = K_LBRACE;   end
                    "}": begin b_v = 1'b1; b_kind = K_RBRACE;   end
                    "[": begin b_v = 1'b1; b_kind = K_LBRACKET; end
                    "]": begin b_v = 1'b1; b_kind = K_RBRACKET; end
                    ";": begin b_v = 1'b1; b_kind = K_SEMI;     end
                    ",": begin b_v = 1'b1; b_kind = K_COMMA;    end
                    ".": begin b_v = 1'b1; b_kind = K_DOT;      end
                    "*": begin b_v = 1'b1; b_kind = K_MUL;      end
                    default: begin b_v = 1'b1; b_kind = K_ERR;  end
                endcase
            end
        end

        // Lexeme count and prefix capture
        if (do_count)
            cnt1 = (cnt_base == LEN_MAX) ? cnt_base : cnt_base + LEN_BITS'(1);
        else
            cnt1 = cnt_base;
        pfx_we  = do_count && (cnt_base < LEN_BITS'(PREFIX_CHARS));
        pfx_idx = cnt_base[IDX_BITS-1:0];

        if (str_close)
        begin
            a_v    = 1'b1;
            a_kind = K_STR;
            a_len  = cnt1;
        end

        if (item.has_char && (pos_reg != POS_MAX))
            pos1 = pos_reg + POS_BITS'(1);
        else
            pos1 = pos_reg;
    end

    assign kw_fin   = ctok_kw_kind(nxt7, cnt1);
    assign pend_fin = pend(mode1, kw_fin);

    // End of source: pending token, then end token
    always_comb
    begin
        unc     = 1'b0;
        f_v     = 1'b0;
        f_kind  = K_ERR;
        f_start = start1;
        f_len   = LEN_BITS'(1);
        if ((mode1 == M_BLOCK) || (mode1 == M_BLOCK_STAR))
            unc = 1'b1;
        else if ((mode1 == M_STR) || (mode1 == M_STR_ESC))
        begin
            f_v   = 1'b1;
            f_len = cnt1;
        end
        else
        begin
            f_v    = pend_fin[KIND_BITS];
            f_kind = pend_fin[KIND_BITS-1:0];
            if ((mode1 == M_NUM) || (mode1 == M_IDENT))
                f_len = cnt1;
        end
        if (!item.end_of_input)
            f_v = 1'b0;
    end

    // Pack tokens in order
    always_comb
    begin
        burst = '0;
        k     = '0;
        if (a_v)
        begin
            burst.tok[k].token_kind   = a_kind;
            burst.tok[k].token_start  = start_reg;
            burst.tok[k].token_length = a_len;
            k = k + 2'd1;
        end
        if (b_v)
        begin
            burst.tok[k].token_kind   = b_kind;
            burst.tok[k].token_start  = pos_reg;
            burst.tok[k].token_length = LEN_BITS'(1);
            k = k + 2'd1;
        end
        if (f_v)
        begin
            burst.tok[k].token_kind   = f_kind;
            burst.tok[k].token_start  = f_start;
            burst.tok[k].token_length = f_len;
            k = k + 2'd1;
        end
        if (item.end_of_input)
        begin
            burst.tok[k].token_kind       = K_END;
            burst.tok[k].token_start      = pos1;
            burst.tok[k].token_length     = '0;
            burst.tok[k].unclosed_comment = unc;
            k = k + 2'd1;
        end
        if (k != 2'd0)
            burst.tok[k - 2'd1].last_of_run = 1'b1;
        burst.n = k;
    end

    // Next state; end of source returns to the reset state
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            if (item.end_of_input)
            begin
                mode_next  = M_IDLE;
                pos_next   = '0;
                start_next = '0;
                cnt_next   = '0;
            end
            else
            begin
                mode_next  = mode1;
                pos_next   = pos1;
                start_next = start1;
                cnt_next   = cnt1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Lexeme prefix store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && pfx_we)
            pfx_reg[pfx_idx] <= c;
    end

endmodule

`default_nettype wire

/* rtl/c_like_lexical_tokenizer.sv */
// Top level of the C-like tokenizer: scanner plus a four-entry token buffer.
//
// Usage: one source character per item on src (ch with has_char set, and
// end_of_input on the last item, which may also carry no character). Tokens
// leave on tok, each with kind, start offset, length, the unclosed-comment
// flag on the end token, and last_of_run on the final token of an item.
// An item causes zero to three tokens. The scanner decides them in the
// cycle the item is accepted; they enter the token buffer at that edge and
// the first one is presented on tok once it reaches the buffer head register.
// Throughput: one item per cycle while tok_ready stays high and each item
// yields at most one token; an item yielding several tokens uses the output
// port once per token, one token per cycle while tok_ready is high.
// src_ready is high while the buffer holds at most one token, so a new item
// is taken even while a finished token waits; if tok stalls, the buffer fills
// and src_ready drops until the receiver takes tokens again.
// Reset: scanner idle at offset zero, buffer empty. After an end token the
// scanner returns to the same state and the next item starts a new source.
`default_nettype none

module c_like_lexical_tokenizer #(
    parameter int PREFIX_CHARS = ctok_pkg::PREFIX_CHARS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_ready,
    input  wire ctok_pkg::ctok_in_t src_item,
    output logic                    tok_valid,
    input  wire logic               tok_ready,
    output ctok_pkg::ctok_out_t     tok_item
);
    import ctok_pkg::*;

    localparam int BUF_DEPTH = 4;

    logic        accept, pop;
    ctok_burst_t burst;
    ctok_out_t   buf_reg  [BUF_DEPTH];
    ctok_out_t   buf_next [BUF_DEPTH];
    logic [2:0]  cnt_reg, cnt_next, base;

    assign src_ready = (cnt_reg <= 3'd1);
    assign accept    = src_valid && src_ready;
    assign tok_valid = (cnt_reg != 3'd0);
    assign tok_item  = buf_reg[0];
    assign pop       = tok_valid && tok_ready;

    ctok_scan #(
        .PREFIX_CHARS (PREFIX_CHARS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_item),
        .burst  (burst)
    );

    // Token buffer: shift out at the head, append new tokens behind
    always_comb
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
            buf_next[i] = buf_reg[i];
        base = cnt_reg - {2'b00, pop};
        if (pop)
        begin
            for (int i = 0; i < BUF_DEPTH - 1; i++)
                buf_next[i] = buf_reg[i + 1];
        end
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < burst.n)
                    buf_next[2'(base + 3'(i))] = burst.tok[i];
            end
            cnt_next = base + {1'b0, burst.n};
        end
        else
            cnt_next = base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
            buf_reg[i] <= buf_next[i];
    end

endmodule

`default_nettype wire

/* sim/c_like_lexical_tokenizer_test.sv */
// Self-checking testbench for the C-like tokenizer: random sources, token predictor, scoreboard.
module c_like_lexical_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ctok_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Scanner modes of the token predictor
    typedef enum logic [4:0] {
        LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_STR, LX_STR_ESC,
        LX_NUM, LX_IDENT, LX_PLUS, LX_MINUS, LX_EQ, LX_BANG, LX_LT, LX_GT,
        LX_AMP, LX_BAR
    } lex_mode_e;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    ctok_in_t  src_item = '0;
    logic      tok_valid;
    logic      tok_ready = 1'b0;
    ctok_out_t tok_item;

    c_like_lexical_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    always #10 clk = ~clk;

    // Keyword spellings in kind order, operator spellings for stimulus
    string kw_words [17] = '{
        "struct", "int", "string", "bool", "if", "else", "while", "do", "for",
        "switch", "case", "default", "break", "true", "false", "printf", "return"
    };
    string op_words [28] = '{
        "++", "+", "--", "-", "/", "(", ")", "{", "}", "[", "]", ";", ",", ".",
        "*", "==", "=>", "=", "!=", "!", "<=", "<", ">=", ">", "&&", "&", "||", "|"
    };
    // Letters and underscore first (0..52), then digits (53..62)
    string word_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string block_pool = " x*\n/";

    ctok_in_t   stim_q[$];
    ctok_out_t  exp_tokens[$];
    ctok_out_t  step_toks[$];
    logic [7:0] text_q[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int          planned_items = 0;
    int          sources_made = 0;
    int          items_taken = 0;
    int          tokens_checked = 0;
    int          error_count = 0;

    // Predictor state
    lex_mode_e           lx_mode;
    logic [POS_BITS-1:0] lx_pos;
    logic [POS_BITS-1:0] lx_begin;
    logic [LEN_BITS-1:0] lx_count;
    logic [7:0]          lx_prefix [PREFIX_CHARS_DEF];

    //--------------------------------------------------------------------
    // Token predictor
    //--------------------------------------------------------------------
    function automatic logic decimal(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic blank(logic [7:0] c);
        return c == " " || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic void clear_scanner();
        lx_mode = LX_IDLE;
        lx_pos = '0;
        lx_begin = '0;
        lx_count = '0;
        foreach (lx_prefix[i])
            lx_prefix[i] = '0;
    endfunction

    function automatic void add_token(logic [KIND_BITS-1:0] kind, logic [POS_BITS-1:0] start,
                                      logic [LEN_BITS-1:0] len, logic unclosed);
        ctok_out_t t;
        if (step_toks.size() >= 3)
            return;
        t.token_kind = kind;
        t.token_start = start;
        t.token_length = len;
        t.unclosed_comment = unclosed;
        t.last_of_run = 1'b0;
        step_toks.push_back(t);
    endfunction

    // Append a lexeme character; only the first few are kept for keyword lookup
    function automatic void keep_char(logic [7:0] c);
        if (lx_count < PREFIX_CHARS_DEF)
            lx_prefix[lx_count] = c;
        if (lx_count != LEN_MAX)
            lx_count++;
    endfunction

    function automatic logic [KIND_BITS-1:0] word_kind();
        logic hit;
        if (lx_count <= PREFIX_CHARS_DEF)
        begin
            for (int k = 0; k < 17; k++)
            begin
                if (lx_count == kw_words[k].len())
                begin
                    hit = 1'b1;
                    for (int i = 0; i < kw_words[k].len(); i++)
                        if (lx_prefix[i] != 8'(kw_words[k][i]))
                            hit = 1'b0;
                    if (hit)
                        return K_KW0 + KIND_BITS'(k);
                end
            end
        end
        return K_ID;
    endfunction

    // Pending token as it stands when the next character does not extend it
    function automatic void close_pending();
        case (lx_mode)
            LX_SLASH: add_token(K_DIV, lx_begin, 1, 1'b0);
            LX_NUM:   add_token(K_NUM, lx_begin, lx_count, 1'b0);
            LX_IDENT: add_token(word_kind(), lx_begin, lx_count, 1'b0);
            LX_PLUS:  add_token(K_PLUS, lx_begin, 1, 1'b0);
            LX_MINUS: add_token(K_MINUS, lx_begin, 1, 1'b0);
            LX_EQ:    add_token(K_ASSIGN, lx_begin, 1, 1'b0);
            LX_BANG:  add_token(K_NOT, lx_begin, 1, 1'b0);
            LX_LT:    add_token(K_LT, lx_begin, 1, 1'b0);
            LX_GT:    add_token(K_GT, lx_begin, 1, 1'b0);
            LX_AMP:   add_token(K_AMP, lx_begin, 1, 1'b0);
            LX_BAR:   add_token(K_ERR, lx_begin, 1, 1'b0);
            default: ;
        endcase
        lx_mode = LX_IDLE;
    endfunction

    // First character of a token, scanner idle
    function automatic void open_token(logic [7:0] c);
        lx_begin = lx_pos;
        lx_count = '0;
        if (blank(c))
            return;
        if (c == CH_QUOTE)
        begin
            keep_char(c);
            lx_mode = LX_STR;
            return;
        end
        if (decimal(c))
        begin
            keep_char(c);
            lx_mode = LX_NUM;
            return;
        end
        if (letter(c) || c == "_")
        begin
            keep_char(c);
            lx_mode = LX_IDENT;
            return;
        end
        case (c)
            "/": lx_mode = LX_SLASH;
            "+": lx_mode = LX_PLUS;
            "-": lx_mode = LX_MINUS;
            "=": lx_mode = LX_EQ;
            "!": lx_mode = LX_BANG;
            "<": lx_mode = LX_LT;
            ">": lx_mode = LX_GT;
            "&": lx_mode = LX_AMP;
            "|": lx_mode = LX_BAR;
            "(": add_token(K_LPAREN, lx_pos, 1, 1'b0);
            ")": add_token(K_RPAREN, lx_pos, 1, 1'b0);
            "{": add_token(K_LBRACE, lx_pos, 1, 1'b0);
            "}": add_token(K_RBRACE, lx_pos, 1, 1'b0);
            "[": add_token(K_LBRACKET, lx_pos, 1, 1'b0);
            "]": add_token(K_RBRACKET, lx_pos, 1, 1'b0);
            ";": add_token(K_SEMI, lx_pos, 1, 1'b0);
            ",": add_token(K_COMMA, lx_pos, 1, 1'b0);
            ".": add_token(K_DOT, lx_pos, 1, 1'b0);
            "*": add_token(K_MUL, lx_pos, 1, 1'b0);
            default: add_token(K_ERR, lx_pos, 1, 1'b0);
        endcase
    endfunction

    function automatic void pair_op(logic [KIND_BITS-1:0] kind);
        add_token(kind, lx_begin, 2, 1'b0);
        lx_mode = LX_IDLE;
    endfunction

    function automatic void feed_char(logic [7:0] c);
        case (lx_mode)
            LX_IDLE:
            begin
                open_token(c);
                return;
            end
            LX_LINE:
            begin
                if (c == CH_LF)
                    lx_mode = LX_IDLE;
                return;
            end
            LX_BLOCK:
            begin
                if (c == "*")
                    lx_mode = LX_BLOCK_STAR;
                return;
            end
            LX_BLOCK_STAR:
            begin
                if (c == "/")
                    lx_mode = LX_IDLE;
                else if (c != "*")
                    lx_mode = LX_BLOCK;
                return;
            end
            LX_STR:
            begin
                keep_char(c);
                if (c == CH_QUOTE)
                begin
                    add_token(K_STR, lx_begin, lx_count, 1'b0);
                    lx_mode = LX_IDLE;
                end
                else if (c == CH_BSLASH)
                    lx_mode = LX_STR_ESC;
                return;
            end
            LX_STR_ESC:
            begin
                keep_char(c);
                lx_mode = LX_STR;
                return;
            end
            LX_SLASH:
            begin
                if (c == "/")
                begin
                    lx_mode = LX_LINE;
                    return;
                end
                if (c == "*")
                begin
                    lx_mode = LX_BLOCK;
                    return;
                end
            end
            LX_NUM:
            begin
                if (decimal(c))
                begin
                    keep_char(c);
                    return;
                end
            end
            LX_IDENT:
            begin
                if (letter(c) || decimal(c) || c == "_")
                begin
                    keep_char(c);
                    return;
                end
            end
            LX_PLUS:
            begin
                if (c == "+")
                begin
                    pair_op(K_INC);
                    return;
                end
            end
            LX_MINUS:
            begin
                if (c == "-")
                begin
                    pair_op(K_DEC);
                    return;
                end
            end
            LX_EQ:
            begin
                if (c == "=")
                begin
                    pair_op(K_EQ);
                    return;
                end
                if (c == ">")
                begin
                    pair_op(K_ARROW);
                    return;
                end
            end
            LX_BANG:
            begin
                if (c == "=")
                begin
                    pair_op(K_NE);
                    return;
                end
            end
            LX_LT:
            begin
                if (c == "=")
                begin
                    pair_op(K_LE);
                    return;
                end
            end
            LX_GT:
            begin
                if (c == "=")
                begin
                    pair_op(K_GE);
                    return;
                end
            end
            LX_AMP:
            begin
                if (c == "&")
                begin
                    pair_op(K_AND);
                    return;
                end
            end
            LX_BAR:
            begin
                if (c == "|")
                begin
                    pair_op(K_OR);
                    return;
                end
            end
            default: ;
        endcase
        // Character does not extend the pending token
        close_pending();
        open_token(c);
    endfunction

    // Expected tokens for one accepted source item
    function automatic void scan_item(ctok_in_t it);
        logic open_block;
        step_toks.delete();
        if (it.has_char)
        begin
            feed_char(it.ch);
            if (lx_pos != POS_MAX)
                lx_pos++;
        end
        if (it.end_of_input)
        begin
            open_block = (lx_mode == LX_BLOCK) || (lx_mode == LX_BLOCK_STAR);
            if (!open_block)
            begin
                if (lx_mode == LX_STR || lx_mode == LX_STR_ESC)
                    add_token(K_ERR, lx_begin, lx_count, 1'b0);
                else
                    close_pending();
            end
            add_token(K_END, lx_pos, '0, open_block);
            clear_scanner();
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last_of_run = 1'b1;
        foreach (step_toks[i])
            exp_tokens.push_back(step_toks[i]);
    endfunction

    //--------------------------------------------------------------------
    // Source driver
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic busy;
        if (rst_n)
        begin
            busy = src_valid;
            if (src_valid && src_ready)
            begin
                scan_item(src_item);
                items_taken++;
                busy = 1'b0;
            end
            // Hold an offered item until taken, otherwise maybe offer the next one
            if (!busy)
            begin
                if (stim_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    src_item <= stim_q.pop_front();
                    src_valid <= 1'b1;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------
    // Token monitor and scoreboard
    //--------------------------------------------------------------------
    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        $display("%0t: token %0d %s mismatch, expected %0d, actual %0d",
                 $time, tokens_checked, name, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        ctok_out_t want;
        if (rst_n && tok_valid && tok_ready)
        begin
            if (exp_tokens.size() == 0)
            begin
                $display("%0t: unexpected token, actual kind %0d start %0d length %0d",
                         $time, tok_item.token_kind, tok_item.token_start,
                         tok_item.token_length);
                error_count++;
            end
            else
            begin
                want = exp_tokens.pop_front();
                if (tok_item.token_kind !== want.token_kind)
                    report_field("kind", want.token_kind, tok_item.token_kind);
                if (tok_item.token_start !== want.token_start)
                    report_field("start", want.token_start, tok_item.token_start);
                if (tok_item.token_length !== want.token_length)
                    report_field("length", want.token_length, tok_item.token_length);
                if (tok_item.unclosed_comment !== want.unclosed_comment)
                    report_field("unclosed_comment", want.unclosed_comment,
                                 tok_item.unclosed_comment);
                if (tok_item.last_of_run !== want.last_of_run)
                    report_field("last_of_run", want.last_of_run, tok_item.last_of_run);
            end
            tokens_checked++;
        end
        tok_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    //--------------------------------------------------------------------
    // Stimulus generation
    //--------------------------------------------------------------------
    task automatic push_item(logic [7:0] c, logic has, logic fin);
        ctok_in_t it;
        it.ch = c;
        it.has_char = has;
        it.end_of_input = fin;
        stim_q.push_back(it);
        if (has || fin)
            planned_items++;
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(8'(s[i]));
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(3))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_CR;
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // String body: plain text, escapes of any byte, and high bytes
    function automatic void add_string_body(int n);
        repeat (n)
        begin
            case ($urandom_range(7))
                0:
                begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(8'($urandom_range(255)));
                end
                1: text_q.push_back(8'($urandom_range(128, 255)));
                default: text_q.push_back(8'(word_pool[$urandom_range(62)]));
            endcase
        end
    endfunction

    function automatic void add_lexeme();
        string kw;
        int    n;
        case ($urandom_range(11))
            0, 1:
            begin
                // Keyword, sometimes extended or cut short into a plain word
                kw = kw_words[$urandom_range(16)];
                case ($urandom_range(3))
                    0: put_text({kw, string'(word_pool[$urandom_range(62)])});
                    1: put_text(kw.substr(0, kw.len() - 2));
                    default: put_text(kw);
                endcase
            end
            2, 3:
            begin
                n = $urandom_range(1, 12);
                text_q.push_back(8'(word_pool[$urandom_range(52)]));
                repeat (n - 1)
                    text_q.push_back(8'(word_pool[$urandom_range(62)]));
            end
            4:
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                repeat (n)
                    text_q.push_back(8'($urandom_range("0", "9")));
            end
            5:
            begin
                text_q.push_back(CH_QUOTE);
                add_string_body($urandom_range(0, 6));
                text_q.push_back(CH_QUOTE);
            end
            6, 7: put_text(op_words[$urandom_range(27)]);
            8: text_q.push_back(ws_byte());
            9:
            begin
                put_text("//");
                repeat ($urandom_range(0, 6))
                    text_q.push_back(printable());
                text_q.push_back(CH_LF);
            end
            10:
            begin
                put_text("/*");
                repeat ($urandom_range(0, 6))
                    text_q.push_back(8'(block_pool[$urandom_range(4)]));
                put_text("*/");
            end
            default: text_q.push_back(8'($urandom_range(255)));
        endcase
    endfunction

    // Turn the text into items, with scattered empty items and an end marker
    task automatic queue_text(logic end_on_char);
        for (int i = 0; i < text_q.size(); i++)
        begin
            if ($urandom_range(24) == 0)
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            push_item(text_q[i], 1'b1, end_on_char && (i == text_q.size() - 1));
        end
        if (!end_on_char || text_q.size() == 0)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
        sources_made++;
    endtask

    task automatic build_source();
        text_q.delete();
        repeat ($urandom_range(0, 12))
        begin
            add_lexeme();
            if ($urandom_range(1))
                text_q.push_back(ws_byte());
        end
        // Some sources end broken: open string, open block comment, open line comment
        case ($urandom_range(19))
            0, 1:
            begin
                text_q.push_back(CH_QUOTE);
                add_string_body($urandom_range(0, 4));
                if ($urandom_range(1))
                    text_q.push_back(CH_BSLASH);
            end
            2, 3:
            begin
                put_text("/*");
                repeat ($urandom_range(0, 4))
                    text_q.push_back(8'(block_pool[$urandom_range(4)]));
                if ($urandom_range(1))
                    text_q.push_back("*");
            end
            4: put_text("// open");
            default: ;
        endcase
        queue_text($urandom_range(1));
    endtask

    task automatic make_sources(int count);
        int target;
        target = planned_items + count;
        while (planned_items < target)
            build_source();
    endtask

    // Wait until every queued item is taken and every token has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (stim_q.size() != 0 || src_valid || exp_tokens.size() != 0);
    endtask

    task automatic directed_items();
        // Empty item, then an empty source
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // Extreme bytes are unknown characters
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        // Lone bar, then a logical or
        push_item("|", 1'b1, 1'b0);
        push_item(" ", 1'b1, 1'b0);
        push_item("|", 1'b1, 1'b0);
        push_item("|", 1'b1, 1'b0);
        // Slash on the final item is a divide
        push_item("/", 1'b1, 1'b1);
        // Unterminated string ending in a backslash
        push_item(CH_QUOTE, 1'b1, 1'b0);
        push_item("a", 1'b1, 1'b0);
        push_item(CH_BSLASH, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        // Slash star slash leaves the comment open
        push_item("/", 1'b1, 1'b0);
        push_item("*", 1'b1, 1'b0);
        push_item("/", 1'b1, 1'b0);
        push_item(" ", 1'b1, 1'b1);
        // Comment open with a trailing star at the end
        push_item("/", 1'b1, 1'b0);
        push_item("*", 1'b1, 1'b0);
        push_item("*", 1'b1, 1'b1);
        // Final item yields three tokens: plus, paren, end
        push_item("x", 1'b1, 1'b0);
        push_item("+", 1'b1, 1'b0);
        push_item("(", 1'b1, 1'b1);
        sources_made += 6;
    endtask

    initial
    begin
        clear_scanner();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles a little, receiver often
        tx_idle_pct = 12;
        rx_idle_pct = 58;
        directed_items();
        make_sources(170);
        wait_drained();

        // Sender idles often, receiver a little
        tx_idle_pct = 58;
        rx_idle_pct = 12;
        make_sources(170);
        wait_drained();

        // Full rate
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        make_sources(160);
        wait_drained();

        // Let any stray token show up
        repeat (16) @(posedge clk);
        if (exp_tokens.size() != 0)
        begin
            $display("%0t: %0d expected tokens never arrived", $time, exp_tokens.size());
            error_count++;
        end

        $display("Ran %0d items in %0d sources, %0d tokens checked, %0d errors.",
                 items_taken, sources_made, tokens_checked, error_count);
        $display("Three pacing profiles over random sources plus directed corner cases.");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("%0t: run did not complete in time", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
